// ----- rtl/core/bilinear_spring_connector_force_core_assert.svh -----
// Assertion helpers for the connector core.
// Each helper expects signals named clock and reset in the enclosing module.
`ifndef BILINEAR_SPRING_CONNECTOR_FORCE_CORE_ASSERT_SVH
`define BILINEAR_SPRING_CONNECTOR_FORCE_CORE_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define BSCF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bscf assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define BSCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bscf assertion failed");
`endif

// ----- rtl/core/bscf_pkg.sv -----
`default_nettype none

package bscf_pkg;

   localparam int POS_WIDTH_DEF = 24;
   localparam int NCELL         = 4;
   localparam int NPAIR         = NCELL * NCELL;
   localparam int NOUT          = 2 * NCELL;

   localparam int WFIELD_W      = 16;
   localparam int CORNER_W      = 2 * WFIELD_W;
   localparam int CPROD_W       = 2 * CORNER_W;
   localparam int PAIR_SHIFT    = 45;
   localparam int PAIR_W        = CPROD_W - PAIR_SHIFT;
   localparam int ANCHOR_SHIFT  = 15;
   localparam int ANCHOR_W      = 24;
   localparam int STIFF_W       = 16;
   localparam int FORCE_W       = 32;
   localparam int SUM_SHIFT     = 15;
   localparam int STIFF_SHIFT   = 12;

   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;

   typedef enum logic [1:0] {
      MODE_ACC_ACC = 2'd0,
      MODE_ACC_ANC = 2'd1,
      MODE_ANC_ACC = 2'd2,
      MODE_OFF     = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE      = 3'd0,
      CSR_PRESENT   = 3'd1,
      CSR_WEIGHTS_A = 3'd2,
      CSR_WEIGHTS_B = 3'd3,
      CSR_ANCHOR_A  = 3'd4,
      CSR_ANCHOR_B  = 3'd5,
      CSR_STIFFNESS = 3'd6
   } csr_index_type;

   typedef struct packed {
      mode_type                    mode;
      logic [NCELL-1:0]            mask_a;
      logic [NCELL-1:0]            mask_b;
      logic [4*WFIELD_W-1:0]       weights_a;
      logic [4*WFIELD_W-1:0]       weights_b;
      logic signed [ANCHOR_W-1:0]  anchor_a;
      logic signed [ANCHOR_W-1:0]  anchor_b;
      logic signed [STIFF_W-1:0]   stiffness;
   } cfg_type;

   // Per-word control that rides down the pipeline next to the data.
   typedef struct packed {
      logic [NOUT-1:0]             en;
      logic signed [STIFF_W-1:0]   stiffness;
   } ctl_type;

   localparam logic signed [STIFF_W-1:0] STIFF_RESET = 16'sd4096;

   localparam cfg_type CFG_RESET = '{
      mode:      MODE_OFF,
      mask_a:    '0,
      mask_b:    '0,
      weights_a: '0,
      weights_b: '0,
      anchor_a:  '0,
      anchor_b:  '0,
      stiffness: STIFF_RESET
   };

   // Width of a position difference, wide enough for positions and anchors.
   function automatic int diff_width(input int pos_w);
      return ((pos_w > ANCHOR_W) ? pos_w : ANCHOR_W) + 1;
   endfunction

   // Width of one difference times pair weight product.
   function automatic int term_width(input int pos_w);
      return diff_width(pos_w) + PAIR_W + 1;
   endfunction

   // Width of a per-cell sum of four terms, negation included.
   function automatic int sum_width(input int pos_w);
      return term_width(pos_w) + 3;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bscf_weight.sv -----
`default_nettype none
`include "bilinear_spring_connector_force_core_assert.svh"

module bscf_weight #(
   parameter int POS_WIDTH = bscf_pkg::POS_WIDTH_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_stall,
   input  bscf_pkg::cfg_type                              cfg,
   input  logic signed [POS_WIDTH-1:0]                    pos_a [bscf_pkg::NCELL],
   input  logic signed [POS_WIDTH-1:0]                    pos_b [bscf_pkg::NCELL],
   output logic                                           out_valid,
   input  logic                                           out_stall,
   output logic signed [bscf_pkg::diff_width(POS_WIDTH)-1:0] diff [bscf_pkg::NPAIR],
   output logic [bscf_pkg::PAIR_W-1:0]                    pair [bscf_pkg::NPAIR],
   output bscf_pkg::ctl_type                              ctl
);
   import bscf_pkg::*;

   localparam int DIFF_W = diff_width(POS_WIDTH);

   // Stage 1: corner weight products and a snapshot of the settings.
   logic                        v1_ff;
   logic [CORNER_W-1:0]         ca_in [NCELL];
   logic [CORNER_W-1:0]         cb_in [NCELL];
   logic [CORNER_W-1:0]         ca_ff [NCELL];
   logic [CORNER_W-1:0]         cb_ff [NCELL];
   logic signed [POS_WIDTH-1:0] pa_ff [NCELL];
   logic signed [POS_WIDTH-1:0] pb_ff [NCELL];
   mode_type                    mode1_ff;
   logic [NCELL-1:0]            ma1_ff;
   logic [NCELL-1:0]            mb1_ff;
   logic signed [ANCHOR_W-1:0]  anchor_a1_ff;
   logic signed [ANCHOR_W-1:0]  anchor_b1_ff;
   ctl_type                     ctl1_in;
   ctl_type                     ctl1_ff;

   // Stage 2: pair weights and position differences.
   logic                        v2_ff;
   logic [PAIR_W-1:0]           pair_in [NPAIR];
   logic [PAIR_W-1:0]           pair_ff [NPAIR];
   logic signed [DIFF_W-1:0]    diff_in [NPAIR];
   logic signed [DIFF_W-1:0]    diff_ff [NPAIR];
   ctl_type                     ctl2_ff;
   logic                        pair_nz;

   logic en1;
   logic en2;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   // Cell a uses X*Y, b uses X_*Y, c uses X*Y_, d uses X_*Y_.
   always_comb begin
      logic [WFIELD_W-1:0] xa, ya, xb, yb;
      for (int i = 0; i < NCELL; i++) begin
         xa = (i % 2 == 1) ? cfg.weights_a[2*WFIELD_W-1:WFIELD_W]   : cfg.weights_a[WFIELD_W-1:0];
         ya = (i / 2 == 1) ? cfg.weights_a[4*WFIELD_W-1:3*WFIELD_W]
                           : cfg.weights_a[3*WFIELD_W-1:2*WFIELD_W];
         xb = (i % 2 == 1) ? cfg.weights_b[2*WFIELD_W-1:WFIELD_W]   : cfg.weights_b[WFIELD_W-1:0];
         yb = (i / 2 == 1) ? cfg.weights_b[4*WFIELD_W-1:3*WFIELD_W]
                           : cfg.weights_b[3*WFIELD_W-1:2*WFIELD_W];
         ca_in[i] = CORNER_W'(xa) * CORNER_W'(ya);
         cb_in[i] = CORNER_W'(xb) * CORNER_W'(yb);
      end
      ctl1_in.stiffness = cfg.stiffness;
      ctl1_in.en[NCELL-1:0] =
         (cfg.mode == MODE_ACC_ACC || cfg.mode == MODE_ACC_ANC) ? cfg.mask_a : '0;
      ctl1_in.en[NOUT-1:NCELL] =
         (cfg.mode == MODE_ACC_ACC || cfg.mode == MODE_ANC_ACC) ? cfg.mask_b : '0;
   end

   // In the anchor modes a single row or column of the pair grid carries the
   // anchor term, so the same multipliers and sums serve every mode.
   always_comb begin
      logic [CPROD_W-1:0]       prod;
      logic [PAIR_W-1:0]        e;
      logic                     use_pair;
      logic signed [DIFF_W-1:0] src_a, src_b;
      for (int i = 0; i < NCELL; i++) begin
         for (int j = 0; j < NCELL; j++) begin
            prod = CPROD_W'(ca_ff[i]) * CPROD_W'(cb_ff[j]);
            case (mode1_ff)
               MODE_ACC_ACC: begin
                  use_pair = ma1_ff[i] && mb1_ff[j];
                  e        = prod[CPROD_W-1:PAIR_SHIFT];
               end
               MODE_ACC_ANC: begin
                  use_pair = ma1_ff[i] && (j == 0);
                  e        = PAIR_W'(ca_ff[i][CORNER_W-1:ANCHOR_SHIFT]);
               end
               MODE_ANC_ACC: begin
                  use_pair = mb1_ff[j] && (i == 0);
                  e        = PAIR_W'(cb_ff[j][CORNER_W-1:ANCHOR_SHIFT]);
               end
               default: begin
                  use_pair = 1'b0;
                  e        = '0;
               end
            endcase
            src_a = (mode1_ff == MODE_ANC_ACC && i == 0) ? DIFF_W'(anchor_a1_ff)
                                                         : DIFF_W'(pa_ff[i]);
            src_b = (mode1_ff == MODE_ACC_ANC && j == 0) ? DIFF_W'(anchor_b1_ff)
                                                         : DIFF_W'(pb_ff[j]);
            pair_in[i*NCELL+j] = use_pair ? e : '0;
            diff_in[i*NCELL+j] = src_b - src_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ca_ff        <= ca_in;
         cb_ff        <= cb_in;
         pa_ff        <= pos_a;
         pb_ff        <= pos_b;
         mode1_ff     <= cfg.mode;
         ma1_ff       <= cfg.mask_a;
         mb1_ff       <= cfg.mask_b;
         anchor_a1_ff <= cfg.anchor_a;
         anchor_b1_ff <= cfg.anchor_b;
         ctl1_ff      <= ctl1_in;
      end
      if (en2) begin
         pair_ff <= pair_in;
         diff_ff <= diff_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign diff      = diff_ff;
   assign pair      = pair_ff;
   assign ctl       = ctl2_ff;

   always_comb begin
      pair_nz = 1'b0;
      for (int k = 0; k < NPAIR; k++) begin
         pair_nz = pair_nz | (pair_ff[k] != '0);
      end
   end

   `BSCF_ASSERT_NEXT(a_off_mode_no_pairs, en2 && v1_ff && mode1_ff == MODE_OFF, !pair_nz)

endmodule

`default_nettype wire

// ----- rtl/core/bscf_term.sv -----
`default_nettype none

module bscf_term #(
   parameter int POS_WIDTH = bscf_pkg::POS_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_stall,
   input  logic signed [bscf_pkg::diff_width(POS_WIDTH)-1:0] diff [bscf_pkg::NPAIR],
   input  logic [bscf_pkg::PAIR_W-1:0]                     pair [bscf_pkg::NPAIR],
   input  bscf_pkg::ctl_type                               in_ctl,
   output logic                                            out_valid,
   input  logic                                            out_stall,
   output logic signed [bscf_pkg::sum_width(POS_WIDTH)-1:0] sum [bscf_pkg::NOUT],
   output bscf_pkg::ctl_type                               out_ctl
);
   import bscf_pkg::*;

   localparam int TERM_W = term_width(POS_WIDTH);
   localparam int SUM_W  = sum_width(POS_WIDTH);

   logic                     v3_ff;
   logic                     v4_ff;
   logic signed [TERM_W-1:0] term_in [NPAIR];
   logic signed [TERM_W-1:0] term_ff [NPAIR];
   logic signed [SUM_W-1:0]  sum_in [NOUT];
   logic signed [SUM_W-1:0]  sum_ff [NOUT];
   ctl_type                  ctl3_ff;
   ctl_type                  ctl4_ff;

   logic en3;
   logic en4;

   assign en4      = !v4_ff || !out_stall;
   assign en3      = !v3_ff || en4;
   assign in_stall = !en3;

   // Pair weights are unsigned, so they get a zero sign bit before the multiply.
   always_comb begin
      for (int k = 0; k < NPAIR; k++) begin
         term_in[k] = TERM_W'(diff[k]) * TERM_W'($signed({1'b0, pair[k]}));
      end
   end

   // Side a cells sum along a row, side b cells along a column with the sign flipped.
   always_comb begin
      logic signed [SUM_W-1:0] acc;
      for (int i = 0; i < NCELL; i++) begin
         acc = '0;
         for (int j = 0; j < NCELL; j++) begin
            acc = acc + SUM_W'(term_ff[i*NCELL+j]);
         end
         sum_in[i] = acc;
      end
      for (int j = 0; j < NCELL; j++) begin
         acc = '0;
         for (int i = 0; i < NCELL; i++) begin
            acc = acc + SUM_W'(term_ff[i*NCELL+j]);
         end
         sum_in[NCELL+j] = -acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en3) begin
            v3_ff <= in_valid;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         term_ff <= term_in;
         ctl3_ff <= in_ctl;
      end
      if (en4) begin
         sum_ff  <= sum_in;
         ctl4_ff <= ctl3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign sum       = sum_ff;
   assign out_ctl   = ctl4_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bscf_finish.sv -----
`default_nettype none
`include "bilinear_spring_connector_force_core_assert.svh"

module bscf_finish #(
   parameter int POS_WIDTH = bscf_pkg::POS_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_stall,
   input  logic signed [bscf_pkg::sum_width(POS_WIDTH)-1:0] sum [bscf_pkg::NOUT],
   input  bscf_pkg::ctl_type                               in_ctl,
   output logic                                            out_valid,
   input  logic                                            out_stall,
   output logic signed [bscf_pkg::FORCE_W-1:0]             force_out [bscf_pkg::NOUT]
);
   import bscf_pkg::*;

   localparam int SUM_W  = sum_width(POS_WIDTH);
   localparam int SH_W   = SUM_W - SUM_SHIFT;
   localparam int PROD_W = SH_W + STIFF_W;
   localparam int RES_W  = PROD_W - STIFF_SHIFT;

   localparam logic signed [RES_W-1:0] RES_MAX = {{(RES_W-FORCE_W+1){1'b0}}, {(FORCE_W-1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = {{(RES_W-FORCE_W+1){1'b1}}, {(FORCE_W-1){1'b0}}};

   logic                       v5_ff;
   logic                       v6_ff;
   logic signed [PROD_W-1:0]   prod_in [NOUT];
   logic signed [PROD_W-1:0]   prod_ff [NOUT];
   ctl_type                    ctl5_ff;
   logic signed [FORCE_W-1:0]  force_in [NOUT];
   logic signed [FORCE_W-1:0]  force_ff [NOUT];
   logic [NOUT-1:0]            force_nz;

   logic en5;
   logic en6;

   assign en6      = !v6_ff || !out_stall;
   assign en5      = !v5_ff || en6;
   assign in_stall = !en5;

   // Both shifts round toward minus infinity, which the plain bit drop gives.
   always_comb begin
      for (int k = 0; k < NOUT; k++) begin
         prod_in[k] = PROD_W'($signed(sum[k][SUM_W-1:SUM_SHIFT])) * PROD_W'(in_ctl.stiffness);
      end
   end

   always_comb begin
      logic signed [RES_W-1:0] res;
      for (int k = 0; k < NOUT; k++) begin
         res = $signed(prod_ff[k][PROD_W-1:STIFF_SHIFT]);
         if (!ctl5_ff.en[k]) begin
            force_in[k] = '0;
         end else if (res > RES_MAX) begin
            force_in[k] = RES_MAX[FORCE_W-1:0];
         end else if (res < RES_MIN) begin
            force_in[k] = RES_MIN[FORCE_W-1:0];
         end else begin
            force_in[k] = res[FORCE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en5) begin
            v5_ff <= in_valid;
         end
         if (en6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         prod_ff <= prod_in;
         ctl5_ff <= in_ctl;
      end
      if (en6) begin
         force_ff <= force_in;
      end
   end

   assign out_valid = v6_ff;
   assign force_out = force_ff;

   always_comb begin
      for (int k = 0; k < NOUT; k++) begin
         force_nz[k] = (force_ff[k] != '0);
      end
   end

   `BSCF_ASSERT_NEXT(a_absent_cell_zero, en6 && v5_ff, (force_nz & ~$past(ctl5_ff.en)) == '0)

endmodule

`default_nettype wire

// ----- rtl/core/bilinear_spring_connector_force_core.sv -----
`default_nettype none
`include "bilinear_spring_connector_force_core_assert.svh"

// Spring connector force core. Each request word carries the positions of
// the four corner cells on each side of a connector (signed, 20 fraction
// bits) and yields one response word with the saturated Q12.20 force
// increment of all eight cells. The core is a six-stage pipeline that takes
// one word per clock when the response side is not stalling; the rate is
// set by the stage registers alone, so every connector of a mesh can be
// streamed through back to back. Stages: corner weight products, pair
// weights and position differences, difference times weight products,
// per-cell sums, strength scaling, and rounding with saturation. Idle
// stages fill up under a response stall, so req_stall rises only when all
// six stages hold a word. The settings (mode, presence mask, bilinear
// weights, anchors and strength) are captured together with each word as
// it enters, and should be written through the csr port only while no
// word is in flight. Absent cells add no term and read back zero, as do
// the side not driven in an anchor mode and all cells when disconnected.

module bilinear_spring_connector_force_core #(
   parameter int POS_WIDTH = bscf_pkg::POS_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [POS_WIDTH-1:0]           req_pos_a0,
   input  logic signed [POS_WIDTH-1:0]           req_pos_a1,
   input  logic signed [POS_WIDTH-1:0]           req_pos_a2,
   input  logic signed [POS_WIDTH-1:0]           req_pos_a3,
   input  logic signed [POS_WIDTH-1:0]           req_pos_b0,
   input  logic signed [POS_WIDTH-1:0]           req_pos_b1,
   input  logic signed [POS_WIDTH-1:0]           req_pos_b2,
   input  logic signed [POS_WIDTH-1:0]           req_pos_b3,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_a0,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_a1,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_a2,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_a3,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_b0,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_b1,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_b2,
   output logic signed [bscf_pkg::FORCE_W-1:0]   rsp_force_b3,

   input  logic                                  csr_wr_en,
   input  logic [bscf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bscf_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import bscf_pkg::*;

   localparam int DIFF_W = diff_width(POS_WIDTH);
   localparam int SUM_W  = sum_width(POS_WIDTH);

   // Settings registers. Writes to an unused index are dropped.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MODE: begin
               cfg_ff.mode <= mode_type'(csr_wr_data[1:0]);
            end
            CSR_PRESENT: begin
               cfg_ff.mask_a <= csr_wr_data[NCELL-1:0];
               cfg_ff.mask_b <= csr_wr_data[2*NCELL-1:NCELL];
            end
            CSR_WEIGHTS_A: begin
               cfg_ff.weights_a <= csr_wr_data[4*WFIELD_W-1:0];
            end
            CSR_WEIGHTS_B: begin
               cfg_ff.weights_b <= csr_wr_data[4*WFIELD_W-1:0];
            end
            CSR_ANCHOR_A: begin
               cfg_ff.anchor_a <= $signed(csr_wr_data[ANCHOR_W-1:0]);
            end
            CSR_ANCHOR_B: begin
               cfg_ff.anchor_b <= $signed(csr_wr_data[ANCHOR_W-1:0]);
            end
            CSR_STIFFNESS: begin
               cfg_ff.stiffness <= $signed(csr_wr_data[STIFF_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   logic signed [POS_WIDTH-1:0] pos_a [NCELL];
   logic signed [POS_WIDTH-1:0] pos_b [NCELL];

   assign pos_a[0] = req_pos_a0;
   assign pos_a[1] = req_pos_a1;
   assign pos_a[2] = req_pos_a2;
   assign pos_a[3] = req_pos_a3;
   assign pos_b[0] = req_pos_b0;
   assign pos_b[1] = req_pos_b1;
   assign pos_b[2] = req_pos_b2;
   assign pos_b[3] = req_pos_b3;

   // Links between the pipeline sections.
   logic                     w_valid, w_stall;
   logic signed [DIFF_W-1:0] w_diff [NPAIR];
   logic [PAIR_W-1:0]        w_pair [NPAIR];
   ctl_type                  w_ctl;

   logic                     t_valid, t_stall;
   logic signed [SUM_W-1:0]  t_sum [NOUT];
   ctl_type                  t_ctl;

   logic signed [FORCE_W-1:0] force_out [NOUT];

   bscf_weight #(
      .POS_WIDTH (POS_WIDTH)
   ) u_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .cfg       (cfg_ff),
      .pos_a     (pos_a),
      .pos_b     (pos_b),
      .out_valid (w_valid),
      .out_stall (w_stall),
      .diff      (w_diff),
      .pair      (w_pair),
      .ctl       (w_ctl)
   );

   bscf_term #(
      .POS_WIDTH (POS_WIDTH)
   ) u_term (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (w_valid),
      .in_stall  (w_stall),
      .diff      (w_diff),
      .pair      (w_pair),
      .in_ctl    (w_ctl),
      .out_valid (t_valid),
      .out_stall (t_stall),
      .sum       (t_sum),
      .out_ctl   (t_ctl)
   );

   bscf_finish #(
      .POS_WIDTH (POS_WIDTH)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .in_stall  (t_stall),
      .sum       (t_sum),
      .in_ctl    (t_ctl),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .force_out (force_out)
   );

   assign rsp_force_a0 = force_out[0];
   assign rsp_force_a1 = force_out[1];
   assign rsp_force_a2 = force_out[2];
   assign rsp_force_a3 = force_out[3];
   assign rsp_force_b0 = force_out[4];
   assign rsp_force_b1 = force_out[5];
   assign rsp_force_b2 = force_out[6];
   assign rsp_force_b3 = force_out[7];

   // Back pressure reaches the request side only through a full, stalled pipe.
   `BSCF_ASSERT_NOW(a_stall_needs_full_pipe, req_stall, rsp_valid && rsp_stall)

endmodule

`default_nettype wire
